FILE: src/raycast_column_march_core_assert.svh
// ----------------------------------------------------------------------------
// raycast_column_march_core assertion macros
// Clocked implication checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef RAYCAST_COLUMN_MARCH_CORE_ASSERT_SVH
`define RAYCAST_COLUMN_MARCH_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RCM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("raycast_column_march_core: check failed");

// next-cycle implication, disabled during reset
`define RCM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("raycast_column_march_core: check failed");

`endif

FILE: src/rcm_pkg.sv
// ----------------------------------------------------------------------------
// rcm_pkg
// Fixed constants of the column ray marcher: sine polynomial, register codes.
// ----------------------------------------------------------------------------
package rcm_pkg;

  // sine polynomial coefficients, Q14
  localparam logic [14:0] SIN_A = 15'd25736;
  localparam logic [14:0] SIN_B = 15'd10512;
  localparam logic [14:0] SIN_C = 15'd1160;

  // configuration register indexes
  localparam logic [2:0] REG_VIEWER_X  = 3'd0;
  localparam logic [2:0] REG_VIEWER_Y  = 3'd1;
  localparam logic [2:0] REG_VIEW_ANG  = 3'd2;
  localparam logic [2:0] REG_FOV       = 3'd3;
  localparam logic [2:0] REG_WALL_A    = 3'd4;
  localparam logic [2:0] REG_WALL_B    = 3'd5;
  localparam logic [2:0] REG_WALL_C    = 3'd6;
  localparam logic [2:0] REG_WALL_D    = 3'd7;

  // field widths
  localparam int CFG_W  = 64;
  localparam int ANG_W  = 12;
  localparam int POS_W  = 25;

  typedef logic signed [15:0] sine_t;

endpackage

FILE: src/raycast_column_march_core.sv
// ----------------------------------------------------------------------------
// raycast_column_march_core
// Fixed-step ray march of one screen column through a 16x16 wall bitmap.
// ----------------------------------------------------------------------------
// Channel | Direction | Signals                          | Transfer
// in      | slave     | in_tvalid/in_tready/in_tdata     | column index
// out     | master    | out_tvalid/out_tready/tdata/tuser| hit result
// cfg     | write     | cfg_wr_en/cfg_index/cfg_data     | one register
//
// A column passes through an idle state, the ray angle (multiply, reciprocal
// multiply), the shared multiplier for three sines, the two step increments,
// k + 1 march steps (k the hit step) and the load of the output register.
// A hit past step zero in front of the view adds the height (multiply, load,
// bit-serial divider, saturate); a miss marches all MAX_STEPS steps.
// in_tready is high only while idle; a finished result waits in the output
// register while the next column is taken. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module raycast_column_march_core #(
  parameter int SCREEN_HEIGHT  = 512,
  parameter int RAY_COLUMNS    = 512,
  parameter int MAP_SIZE       = 16,
  parameter int MAX_STEPS      = 400,
  parameter int STEPS_PER_CELL = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [8:0] column_index
  output logic        out_tvalid,
  input  logic        out_tready,
  // [8:0] hit_step, [12:9] hit_cell_x, [16:13] hit_cell_y,
  // [26:17] slice_height, [35:27] column_top, [45:36] screen_column
  output logic [47:0] out_tdata,
  output logic [0:0]  out_tuser,  // [0] wall_hit
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int KW   = $clog2(MAX_STEPS + 1);
  localparam int DIVQ = 4 * STEPS_PER_CELL;
  localparam int DW   = $clog2(DIVQ);
  localparam int PW   = rcm_pkg::POS_W;
  localparam longint H_NUM_L = longint'(SCREEN_HEIGHT) * STEPS_PER_CELL * 16384;
  localparam logic [31:0] H_NUM = 32'(H_NUM_L);
  localparam logic signed [PW-1:0] LIM = PW'(MAP_SIZE * 4096);
  // reciprocals: step increment (shift 22), ray angle (shift 37)
  localparam longint DRECIP = ((longint'(1) << 22) + DIVQ - 1) / DIVQ;
  localparam longint ARECIP = ((longint'(1) << 37) + 2 * RAY_COLUMNS - 1) /
                              (2 * RAY_COLUMNS);

  localparam logic [4:0] S_IDLE = 5'd0,  S_AMUL = 5'd1,  S_ALD  = 5'd2,
                         S_DIV  = 5'd3,  S_ASET = 5'd4,  S_SM0  = 5'd5,
                         S_SM1  = 5'd6,  S_SM2  = 5'd7,  S_SM3  = 5'd8,
                         S_SEND = 5'd9,  S_XLD  = 5'd10, S_XFIX = 5'd11,
                         S_YLD  = 5'd12, S_YFIX = 5'd13, S_MARCH= 5'd14,
                         S_HMUL = 5'd15, S_HLD  = 5'd16, S_HSET = 5'd17,
                         S_FIN  = 5'd18, S_AREC = 5'd19;

  // configuration registers
  logic [15:0] vx_r, vy_r;
  logic [11:0] view_r, fov_r;
  logic [63:0] wa_r, wb_r, wc_r, wd_r;

  logic [4:0]  state_r, ret_r;
  logic [8:0]  idx_r;
  logic [11:0] ang_r;
  logic [1:0]  sel_r;
  logic signed [63:0] prod_r;
  logic [14:0] z2_r;
  rcm_pkg::sine_t cs_r, sn_r, crel_r;

  // divider
  logic [31:0] num_r, den_r, rem_r, quo_r;
  logic [5:0]  cnt_r;

  // march
  logic signed [23:0] qx_r, qy_r;
  logic signed [11:0] incx_r, incy_r;
  logic [DW-1:0] rcx_r, rcy_r, rx_r, ry_r;
  logic [KW-1:0] k_r;
  logic [11:0] h_r;
  logic [3:0]  hx_r, hy_r;
  logic        hit_r;

  logic        out_valid_r;
  logic [47:0] out_data_r;
  logic        out_hit_r;
  logic        fin_go;

  // ---- sine argument for the current selector ----
  logic [11:0] sin_a;
  logic [10:0] qq;
  logic [14:0] zz;
  always_comb begin
    case (sel_r)
      2'd0:    sin_a = ang_r + 12'd1024;
      2'd1:    sin_a = ang_r;
      default: sin_a = ang_r - view_r + 12'd1024;
    endcase
    qq = sin_a[10] ? (11'd1024 - {1'b0, sin_a[9:0]}) : {1'b0, sin_a[9:0]};
    zz = {qq, 4'b0};
  end

  // ---- magnitude of the sine being split into a step increment ----
  logic [15:0] abs_v;
  logic [11:0] h_sat;
  always_comb begin
    abs_v = (state_r == S_XLD || state_r == S_XFIX) ?
            (cs_r[15] ? 16'(-cs_r) : 16'(cs_r)) :
            (sn_r[15] ? 16'(-sn_r) : 16'(sn_r));
    h_sat = (quo_r < 32'(SCREEN_HEIGHT)) ? 12'(quo_r) : 12'(SCREEN_HEIGHT);
  end

  // ---- shared multiplier ----
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic [14:0] t1, t2;
  always_comb begin
    t1 = 15'(rcm_pkg::SIN_B - prod_r[28:14]);
    t2 = 15'(rcm_pkg::SIN_A - prod_r[28:14]);
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_AMUL: begin
        mul_a = $signed({22'b0, idx_r, 1'b0}) - 32'(RAY_COLUMNS);
        mul_b = {20'b0, fov_r};
      end
      S_AREC: begin mul_a = $signed(num_r); mul_b = 32'(ARECIP); end
      S_SM0: begin mul_a = {17'b0, zz}; mul_b = {17'b0, zz}; end
      S_SM1: begin mul_a = {17'b0, rcm_pkg::SIN_C}; mul_b = {17'b0, prod_r[28:14]}; end
      S_SM2: begin mul_a = {17'b0, t1}; mul_b = {17'b0, z2_r}; end
      S_SM3: begin mul_a = {17'b0, t2}; mul_b = {17'b0, zz}; end
      S_XLD, S_YLD: begin mul_a = {16'b0, abs_v}; mul_b = 32'(DRECIP); end
      S_HMUL: begin mul_a = 32'($unsigned(k_r)); mul_b = 32'(crel_r); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    mul_p = mul_a * mul_b;
  end

  // ---- divider step ----
  logic [32:0] rem_sh;
  logic        div_ge;
  logic [4:0]  bit_idx;
  always_comb begin
    bit_idx = 5'(cnt_r - 6'd1);
    rem_sh  = {rem_r, num_r[bit_idx]};
    div_ge  = rem_sh >= {1'b0, den_r};
  end

  // ---- wall test at the current position ----
  logic signed [PW-1:0] px, py;
  logic [255:0] wall_vec;
  logic        is_wall;
  logic [3:0]  cx_cl, cy_cl;
  always_comb begin
    px = $signed({9'b0, vx_r}) + PW'(qx_r);
    py = $signed({9'b0, vy_r}) + PW'(qy_r);
    wall_vec = {wd_r, wc_r, wb_r, wa_r};
    is_wall = px[PW-1] || py[PW-1] || (px >= LIM) || (py >= LIM) ||
              wall_vec[{py[15:12], px[15:12]}];
    if (px[PW-1]) cx_cl = 4'd0;
    else if (px[PW-1:12] > 13'(MAP_SIZE - 1)) cx_cl = 4'(MAP_SIZE - 1);
    else cx_cl = px[15:12];
    if (py[PW-1]) cy_cl = 4'd0;
    else if (py[PW-1:12] > 13'(MAP_SIZE - 1)) cy_cl = 4'(MAP_SIZE - 1);
    else cy_cl = py[15:12];
  end

  // ---- per-step remainder carries ----
  logic [DW:0] rx_sum, ry_sum;
  logic        cx_c, cy_c;
  always_comb begin
    rx_sum = {1'b0, rx_r} + {1'b0, rcx_r};
    ry_sum = {1'b0, ry_r} + {1'b0, rcy_r};
    cx_c = rx_sum >= (DW+1)'(DIVQ);
    cy_c = ry_sum >= (DW+1)'(DIVQ);
  end

  // floor-division fixup of a signed increment
  logic signed [11:0] inc_nxt;
  logic [DW-1:0]      rc_nxt;
  logic               fix_neg;
  logic [10:0]        dq;
  logic [15:0]        dr;
  always_comb begin
    fix_neg = (state_r == S_XFIX) ? cs_r[15] : sn_r[15];
    dq = prod_r[32:22];
    dr = abs_v - 16'(32'(dq) * DIVQ);
    if (!fix_neg) begin
      inc_nxt = 12'(dq);
      rc_nxt  = DW'(dr);
    end else if (dr == '0) begin
      inc_nxt = -12'(dq);
      rc_nxt  = '0;
    end else begin
      inc_nxt = -12'(dq) - 12'sd1;
      rc_nxt  = DW'(16'(DIVQ) - dr);
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_hit_r;
  assign fin_go     = (state_r == S_FIN) && (!out_valid_r || out_tready);

  // ---- configuration writes ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vx_r <= 16'd8192;
      vy_r <= 16'd57344;
      view_r <= 12'd3980;
      fov_r <= 12'd683;
      wa_r <= '0; wb_r <= '0; wc_r <= '0; wd_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        rcm_pkg::REG_VIEWER_X: vx_r   <= cfg_data[15:0];
        rcm_pkg::REG_VIEWER_Y: vy_r   <= cfg_data[15:0];
        rcm_pkg::REG_VIEW_ANG: view_r <= cfg_data[11:0];
        rcm_pkg::REG_FOV:      fov_r  <= cfg_data[11:0];
        rcm_pkg::REG_WALL_A:   wa_r   <= cfg_data;
        rcm_pkg::REG_WALL_B:   wb_r   <= cfg_data;
        rcm_pkg::REG_WALL_C:   wc_r   <= cfg_data;
        rcm_pkg::REG_WALL_D:   wd_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r <= S_IDLE;
      out_valid_r <= 1'b0;
      sel_r <= '0;
      cnt_r <= '0;
    end else begin
      // load the output register or drop it after its transfer
      if (fin_go) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            idx_r <= in_tdata[8:0];
            state_r <= S_AMUL;
          end
        end
        S_AMUL: begin
          prod_r <= mul_p;
          state_r <= S_ALD;
        end
        // angle numerator, then its quotient by twice the column count
        S_ALD: begin
          num_r <= 32'(prod_r + 64'(longint'(8192) * RAY_COLUMNS));
          state_r <= S_AREC;
        end
        S_AREC: begin
          prod_r <= mul_p;
          state_r <= S_ASET;
        end
        S_DIV: begin
          rem_r <= div_ge ? 32'(rem_sh - {1'b0, den_r}) : rem_sh[31:0];
          quo_r <= {quo_r[30:0], div_ge};
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) state_r <= ret_r;
        end
        S_ASET: begin
          ang_r <= view_r + prod_r[48:37];
          sel_r <= 2'd0;
          state_r <= S_SM0;
        end
        S_SM0: begin prod_r <= mul_p; state_r <= S_SM1; end
        S_SM1: begin z2_r <= prod_r[28:14]; prod_r <= mul_p; state_r <= S_SM2; end
        S_SM2: begin prod_r <= mul_p; state_r <= S_SM3; end
        S_SM3: begin prod_r <= mul_p; state_r <= S_SEND; end
        // store the signed sine for this selector
        S_SEND: begin
          case (sel_r)
            2'd0:    cs_r   <= sin_a[11] ? -16'(prod_r[28:14]) : 16'(prod_r[28:14]);
            2'd1:    sn_r   <= sin_a[11] ? -16'(prod_r[28:14]) : 16'(prod_r[28:14]);
            default: crel_r <= sin_a[11] ? -16'(prod_r[28:14]) : 16'(prod_r[28:14]);
          endcase
          if (sel_r == 2'd2) begin
            state_r <= S_XLD;
          end else begin
            sel_r <= sel_r + 2'd1;
            state_r <= S_SM0;
          end
        end
        // reciprocal multiply of the sine magnitude by four times the step count per cell
        S_XLD, S_YLD: begin
          prod_r <= mul_p;
          state_r <= (state_r == S_XLD) ? S_XFIX : S_YFIX;
        end
        S_XFIX: begin
          incx_r <= inc_nxt; rcx_r <= rc_nxt;
          state_r <= S_YLD;
        end
        S_YFIX: begin
          incy_r <= inc_nxt; rcy_r <= rc_nxt;
          qx_r <= '0; qy_r <= '0; rx_r <= '0; ry_r <= '0;
          k_r <= '0;
          state_r <= S_MARCH;
        end
        // test one step, then advance both axes
        S_MARCH: begin
          if (is_wall) begin
            hit_r <= 1'b1;
            hx_r <= cx_cl; hy_r <= cy_cl;
            if (k_r != '0 && !crel_r[15] && crel_r != '0) begin
              state_r <= S_HMUL;
            end else begin
              h_r <= 12'(SCREEN_HEIGHT);
              state_r <= S_FIN;
            end
          end else if (k_r == KW'(MAX_STEPS - 1)) begin
            hit_r <= 1'b0;
            hx_r <= '0; hy_r <= '0; k_r <= '0; h_r <= '0;
            state_r <= S_FIN;
          end else begin
            rx_r <= cx_c ? DW'(rx_sum - (DW+1)'(DIVQ)) : DW'(rx_sum);
            ry_r <= cy_c ? DW'(ry_sum - (DW+1)'(DIVQ)) : DW'(ry_sum);
            qx_r <= qx_r + 24'(incx_r) + {23'b0, cx_c};
            qy_r <= qy_r + 24'(incy_r) + {23'b0, cy_c};
            k_r <= k_r + KW'(1);
          end
        end
        S_HMUL: begin prod_r <= mul_p; state_r <= S_HLD; end
        S_HLD: begin
          num_r <= H_NUM;
          den_r <= prod_r[31:0];
          rem_r <= '0; quo_r <= '0;
          cnt_r <= 6'd32;
          ret_r <= S_HSET;
          state_r <= S_DIV;
        end
        S_HSET: begin h_r <= h_sat; state_r <= S_FIN; end
        // hand the result to the output register once it is free
        S_FIN: begin
          if (fin_go) begin
            out_hit_r <= hit_r;
            out_data_r <= {2'b0,
                           10'(10'(RAY_COLUMNS) + {1'b0, idx_r}),
                           9'(hit_r ? (12'(SCREEN_HEIGHT / 2) - (h_r >> 1)) : 12'd0),
                           10'(h_r), hy_r, hx_r, 9'(k_r)};
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`include "raycast_column_march_core_assert.svh"

  `RCM_ASSERT_NEXT(a_busy_after_take, in_tvalid && in_tready, !in_tready)
  `RCM_ASSERT_SAME(a_step_in_range, state_r == S_MARCH, k_r < KW'(MAX_STEPS))
  `RCM_ASSERT_SAME(a_div_count_live, state_r == S_DIV, cnt_r != 6'd0)
  `RCM_ASSERT_SAME(a_miss_zero_height, out_tvalid && !out_tuser[0], out_tdata[26:17] == 10'd0)

endmodule
